/* rtl/dqc_pkg.sv */
package dqc_pkg;

  localparam int ValueWidth = 32;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_REWIND     = 3'd3;
  localparam logic [2:0] MODE_ADVANCE    = 3'd4;
  localparam logic [2:0] MODE_WRITE      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // shift command broadcast to every cell of the row
  typedef struct packed {
    logic shr;  // push front: every element moves one cell toward the back
    logic shl;  // pop front: every element moves one cell toward the front
  } dqc_shift_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   traversal_done;
    logic [4:0]             element_count;
    logic [ValueWidth-1:0]  cursor_value;
    logic [ValueWidth-1:0]  front_value;
  } dqc_result_t;

endpackage

/* rtl/dqc_cell.sv */
module dqc_cell (
  input  logic                    clk,
  input  dqc_pkg::dqc_shift_t     shift,
  input  logic                    we,
  input  logic [31:0]             wdata,
  input  logic [31:0]             left_q,
  input  logic [31:0]             right_q,
  output logic [31:0]             d,
  output logic [31:0]             q
);
  import dqc_pkg::*;

  always_comb begin
    if (we) begin
      d = wdata;
    end else if (shift.shr) begin
      d = left_q;
    end else if (shift.shl) begin
      d = right_q;
    end else begin
      d = q;
    end
  end

  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

/* rtl/dqc_ctrl.sv */
module dqc_ctrl #(
  parameter int DEPTH = 16,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [2:0]           mode,
  output dqc_pkg::dqc_shift_t  shift,
  output logic                 we,
  output logic [IW-1:0]        widx,
  output logic [1:0]           status,
  output logic [CW-1:0]        count_next,
  output logic [IW-1:0]        cur_next,
  output logic                 active_next
);
  import dqc_pkg::*;

  // cursor is held as an offset from the front of the list
  logic [CW-1:0] count;
  logic [IW-1:0] cur;
  logic          active;
  logic          full;
  logic          empty;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    shift       = '0;
    we          = 1'b0;
    widx        = cur;
    status      = ST_OK;
    count_next  = count;
    cur_next    = cur;
    active_next = active;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          shift.shr  = 1'b1;
          count_next = count + 1'b1;
          if (active) begin
            cur_next = cur + 1'b1;
          end
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we         = 1'b1;
          widx       = count[IW-1:0];
          count_next = count + 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          shift.shl  = 1'b1;
          count_next = count - 1'b1;
          if (active) begin
            if (cur == '0) begin
              if (count == CW'(1)) begin
                active_next = 1'b0;
              end
            end else begin
              cur_next = cur - 1'b1;
            end
          end
        end
      end
      MODE_REWIND: begin
        cur_next    = '0;
        active_next = !empty;
      end
      MODE_ADVANCE: begin
        if (!active) begin
          status = ST_DONE;
        end else if ((CW'(cur) + 1'b1) >= count) begin
          active_next = 1'b0;
        end else begin
          cur_next = cur + 1'b1;
        end
      end
      MODE_WRITE: begin
        if (!active) begin
          status = ST_DONE;
        end else begin
          we = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      shift = '0;
      we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cur    <= '0;
      active <= 1'b0;
    end else if (accept) begin
      count  <= count_next;
      cur    <= cur_next;
      active <= active_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    active |-> (CW'(cur) < count))
    else $error("cursor past end of list while active");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK))
    |=> $stable(count) && $stable(cur))
    else $error("push on full list changed state");

  a_empty_clears_cursor: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !active)
    else $error("cursor active on empty list");
`endif

endmodule

/* rtl/dqc_outbuf.sv */
module dqc_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  dqc_pkg::dqc_result_t  res,
  output logic                  space,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output dqc_pkg::dqc_result_t  m_res
);
  import dqc_pkg::*;

  dqc_result_t skid;
  logic        skid_valid;
  logic        pop;

  assign pop   = m_tvalid && m_tready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load) begin
        if (!m_tvalid || pop) begin
          m_res    <= res;
          m_tvalid <= 1'b1;
        end else begin
          skid       <= res;
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          m_res      <= skid;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/bounded_deque_with_cursor_top.sv */
// A result beat is registered in the output buffer when its input beat is taken.
// Throughput: one input beat per cycle while the output buffer has space; a row
//   of cells shifts the whole list at once on every push front or pop front.
// A two-entry output buffer lets input continue while one result waits.
// Reset (rst, synchronous, active high) empties the list and ends the traversal;
//   cell contents are left as they are.
module bounded_deque_with_cursor_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode[2:0], value[34:3], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // front_value, cursor_value, element_count,
                                 // traversal_done, status
);
  import dqc_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic              accept;
  logic [2:0]        mode;
  logic [31:0]       value;
  dqc_shift_t        shift;
  logic              we;
  logic [IW-1:0]     widx;
  logic [1:0]        status;
  logic [CW-1:0]     count_next;
  logic [IW-1:0]     cur_next;
  logic              active_next;
  logic [31:0]       cell_d [DEPTH];
  logic [31:0]       cell_q [DEPTH];
  dqc_result_t       res;
  dqc_result_t       m_res;
  logic              space;

  assign mode   = s_tdata[2:0];
  assign value  = s_tdata[34:3];
  assign accept = s_tvalid && s_tready;
  assign s_tready = space;

  dqc_ctrl #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .mode        (mode),
    .shift       (shift),
    .we          (we),
    .widx        (widx),
    .status      (status),
    .count_next  (count_next),
    .cur_next    (cur_next),
    .active_next (active_next)
  );

  // cell 0 holds the front; push front feeds the value in from the left
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_q;
    logic [31:0] right_q;
    if (i == 0) begin : g_first
      assign left_q = value;
    end else begin : g_mid
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_inner
      assign right_q = cell_q[i+1];
    end
    dqc_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .we      (we && (widx == IW'(i))),
      .wdata   (value),
      .left_q  (left_q),
      .right_q (right_q),
      .d       (cell_d[i]),
      .q       (cell_q[i])
    );
  end

  always_comb begin
    res.front_value    = (count_next != '0) ? cell_d[0] : '0;
    res.cursor_value   = active_next ? cell_d[cur_next] : '0;
    res.element_count  = 5'(count_next);
    res.traversal_done = !active_next;
    res.status         = status;
  end

  dqc_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .res      (res),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {m_res.status, m_res.traversal_done, m_res.element_count,
                    m_res.cursor_value, m_res.front_value};

endmodule
